// ===== src/bni_pkg.sv =====
// Shared types and constants of the batch normalization inference unit.
// Every other file of the block imports this package, but for bni_ram and bni_fifo.
package bni_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned LD_CH_W    = 8;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned VSUM_W     = 17;
  localparam int unsigned ROOT_W     = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned INNER_W    = 21;
  localparam int unsigned CCOUNT_W   = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 2'd2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam int unsigned IN_QUEUE_DEPTH  = 2;
  localparam int unsigned OUT_QUEUE_DEPTH = 4;

  localparam int unsigned STEP_W     = 6;
  localparam int unsigned ROOT_STEPS = 17;
  localparam int unsigned DIV_STEPS  = 36;

  typedef struct packed {
    logic [INNER_W-1:0]  inner_size;
    logic [CCOUNT_W-1:0] channel_count;
    logic [DATA_W-1:0]   epsilon;
  } cfg_t;

  typedef struct packed {
    logic                     is_sample;
    logic [LD_CH_W-1:0]       channel;
    logic signed [DATA_W-1:0] mean_value;
    logic [DATA_W-1:0]        variance_value;
    logic signed [DATA_W-1:0] scale_value;
    logic signed [DATA_W-1:0] bias_value;
    logic signed [DATA_W-1:0] sample;
  } entry_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean;
    logic signed [GAIN_W-1:0] gain;
    logic signed [DATA_W-1:0] bias;
  } coef_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     saturated;
    logic [LD_CH_W-1:0]       channel_index;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] scale;
    logic [VSUM_W-1:0]        var_sum;
  } gain_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [GAIN_W-1:0] gain;
  } gain_rsp_t;

endpackage

// ===== src/bni_channels.sv =====
// Handshake channel interfaces of the batch normalization inference unit.
// Depends on bni_pkg for field widths.
interface bni_in_if;
  import bni_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [LD_CH_W-1:0]       channel;
  logic signed [DATA_W-1:0] mean_value;
  logic [DATA_W-1:0]        variance_value;
  logic signed [DATA_W-1:0] scale_value;
  logic signed [DATA_W-1:0] bias_value;
  logic signed [DATA_W-1:0] sample;

  modport source (
    output valid, func, channel, mean_value, variance_value, scale_value, bias_value, sample,
    input  ready
  );
  modport sink (
    input  valid, func, channel, mean_value, variance_value, scale_value, bias_value, sample,
    output ready
  );
endinterface

interface bni_out_if;
  import bni_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     saturated;
  logic [LD_CH_W-1:0]       channel_index;

  modport source (output valid, result_value, saturated, channel_index, input ready);
  modport sink (input valid, result_value, saturated, channel_index, output ready);
endinterface

interface bni_cfg_if;
  import bni_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/batch_norm_inference_unit.sv =====
// Batch normalization for inference, Q8.8 samples with Q16.16 channel gains.
// Depends on bni_pkg, bni_channels, bni_front and bni_back.
//
// Usage:
//   cfg_i takes register writes (index 0 inner_size, 1 channel_count,
//   2 epsilon) and is always ready; write it only while the unit is idle.
//   in_i carries load transactions (func 0), which store one channel's mean,
//   gain and bias, and sample transactions (func 1), which each produce one
//   transaction on out_o for the current channel.
//   Samples pass registers s1, s2 and the output queue to out_o, one per cycle
//   while no load runs and the output queue has room. A load occupies the back
//   end while the gain unit runs 17 square root steps and 36 divide steps; the
//   two-entry input queue keeps accepting transactions until full. When out_o
//   stalls, results collect in a four-entry output queue, then the back end
//   stops issuing and the input queue fills and drops in_i.ready. Reset clears
//   the channel and sample counters and sets all three registers to 1.
//   Coefficients are undefined until a channel is loaded.
module batch_norm_inference_unit #(
  parameter int unsigned MAX_CHANNELS   = 256,
  parameter int unsigned MAX_INNER_LOG2 = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bni_cfg_if.sink   cfg_i,
  bni_in_if.sink    in_i,
  bni_out_if.source out_o
);
  import bni_pkg::*;

  cfg_t   cfg_q;
  logic   q_valid, q_ready;
  entry_t q_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_size    <= INNER_W'(1);
      cfg_q.channel_count <= CCOUNT_W'(1);
      cfg_q.epsilon       <= DATA_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_INNER_SIZE:    cfg_q.inner_size    <= cfg_i.data[INNER_W-1:0];
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_i.data[CCOUNT_W-1:0];
        CFG_EPSILON:       cfg_q.epsilon       <= cfg_i.data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  bni_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_ready_i (q_ready)
  );

  bni_back #(
    .MAX_CHANNELS   (MAX_CHANNELS),
    .MAX_INNER_LOG2 (MAX_INNER_LOG2)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_ready_o (q_ready),
    .out_o     (out_o)
  );

endmodule

// ===== src/bni_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bni_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bni_fifo.sv =====
// Small first-in first-out queue built from registers, any packed type.
// No dependencies.
module bni_fifo #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  T              push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output T              pop_data_o,
  output logic [CW-1:0] count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T              mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    logic [AW-1:0] n;
    if (p == AW'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign count_o      = count_q;

  always_comb begin
    wr_ptr_d = push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/bni_gain.sv =====
// Gain unit: scale / sqrt(variance + epsilon) in Q16.16, one root digit
// or one quotient bit per cycle. Depends on bni_pkg.
module bni_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bni_pkg::gain_req_t req_i,
  output bni_pkg::gain_rsp_t rsp_o
);
  import bni_pkg::*;

  localparam int unsigned RAD_W  = 2 * ROOT_STEPS;
  localparam int unsigned REM_W  = ROOT_W + 1;
  localparam int unsigned NUM_W  = DIV_STEPS;
  localparam int unsigned DREM_W = ROOT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  logic [1:0]               state_q, state_d;
  logic                     done_q, done_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic [RAD_W-1:0]         rad_q, rad_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [ROOT_W-1:0]        root_q, root_d;
  logic                     neg_q, neg_d;
  logic [DATA_W-1:0]        mag_q, mag_d;
  logic [NUM_W-1:0]         num_q, num_d;
  logic [DREM_W-1:0]        drem_q, drem_d;
  logic signed [GAIN_W-1:0] gain_q, gain_d;

  logic [REM_W+1:0]  rem_sh, trial;
  logic [DREM_W:0]   dsh, dvs;
  logic              dge;
  logic [GAIN_W-1:0] quo;

  assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign dsh    = {drem_q, num_q[NUM_W-1]};
  assign dvs    = {1'b0, root_q};
  assign dge    = (dsh >= dvs);
  assign quo    = {num_q[GAIN_W-2:0], dge};

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    num_d   = num_q;
    drem_d  = drem_q;
    gain_d  = gain_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          neg_d   = req_i.scale[DATA_W-1];
          mag_d   = req_i.scale[DATA_W-1] ? DATA_W'(-req_i.scale) : req_i.scale;
          rad_d   = {1'b0, req_i.var_sum, 16'b0};
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = REM_W'(rem_sh - trial);
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[REM_W-1:0];
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
          state_d = ST_PREP;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_PREP: begin
        if (root_q == '0) begin
          if (mag_q == '0) begin
            gain_d = '0;
          end else if (neg_q) begin
            gain_d = {1'b1, {(GAIN_W-1){1'b0}}};
          end else begin
            gain_d = {1'b0, {(GAIN_W-1){1'b1}}};
          end
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          num_d   = {mag_q, 20'b0} + NUM_W'(root_q >> 1);
          drem_d  = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        num_d  = {num_q[NUM_W-2:0], dge};
        drem_d = dge ? DREM_W'(dsh - dvs) : dsh[DREM_W-1:0];
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          gain_d  = neg_q ? (~quo + 1'b1) : quo;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    num_q  <= num_d;
    drem_q <= drem_d;
    gain_q <= gain_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.gain = gain_q;

endmodule

// ===== src/bni_front.sv =====
// Front end: accepts input transactions, drops loads to channels that do
// not exist and queues the rest for the back end. Depends on bni_pkg, bni_channels and bni_fifo.
module bni_front #(
  parameter int unsigned MAX_CHANNELS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bni_in_if.sink          in_i,
  output logic            q_valid_o,
  output bni_pkg::entry_t q_data_o,
  input  logic            q_ready_i
);
  import bni_pkg::*;

  entry_t entry;
  logic   keep;
  logic   push_ready;

  assign keep = (in_i.func == FUNC_SAMPLE) || (32'(in_i.channel) < 32'(MAX_CHANNELS));

  always_comb begin
    entry.is_sample      = (in_i.func == FUNC_SAMPLE);
    entry.channel        = in_i.channel;
    entry.mean_value     = in_i.mean_value;
    entry.variance_value = in_i.variance_value;
    entry.scale_value    = in_i.scale_value;
    entry.bias_value     = in_i.bias_value;
    entry.sample         = in_i.sample;
  end

  assign in_i.ready = push_ready;

  bni_fifo #(
    .T     (entry_t),
    .DEPTH (IN_QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid && keep),
    .push_ready_o (push_ready),
    .push_data_i  (entry),
    .pop_valid_o  (q_valid_o),
    .pop_ready_i  (q_ready_i),
    .pop_data_o   (q_data_o),
    .count_o      ()
  );

endmodule

// ===== src/bni_back.sv =====
// Back end: coefficient table, gain unit, channel counters, sample pipeline
// and result queue. Depends on bni_pkg, bni_channels, bni_gain, bni_ram and bni_fifo.
module bni_back #(
  parameter int unsigned MAX_CHANNELS   = 256,
  parameter int unsigned MAX_INNER_LOG2 = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bni_pkg::cfg_t   cfg_i,
  input  logic            q_valid_i,
  input  bni_pkg::entry_t q_data_i,
  output logic            q_ready_o,
  bni_out_if.source       out_o
);
  import bni_pkg::*;

  localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned IN_W   = MAX_INNER_LOG2;
  localparam int unsigned CMP_W  = (IN_W + 1 > INNER_W) ? IN_W + 1 : INNER_W;
  localparam int unsigned OUT_CW = $clog2(OUT_QUEUE_DEPTH + 1);
  localparam int unsigned PROD_W = DATA_W + 1 + GAIN_W;
  localparam int unsigned T_W    = PROD_W + 1;

  logic              busy_q, busy_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [IN_W-1:0]   inner_q, inner_d;
  logic              s1_v_q, s2_v_q;

  logic [CH_W-1:0]          ld_ch_q;
  logic signed [DATA_W-1:0] ld_mean_q, ld_bias_q;
  logic signed [DATA_W-1:0] s1_sample_q;
  logic [CH_W-1:0]          s1_ch_q, s2_ch_q;
  logic signed [PROD_W-1:0] s2_prod_q;
  logic signed [DATA_W-1:0] s2_bias_q;

  logic              pop, pop_sample, pop_load, issue_ok;
  logic [OUT_CW-1:0] out_cnt;
  logic [IN_W:0]     inner_nxt;
  logic [CH_W:0]     ch_nxt;
  logic              inner_wrap, ch_wrap;
  gain_req_t         gain_req;
  gain_rsp_t         gain_rsp;
  coef_t             coef_wr, coef_rd;

  logic signed [DATA_W:0]    diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [T_W-1:0]     bias_sh, t_sum;
  logic signed [T_W-17:0]    y;
  logic                      sat;
  out_item_t                 item, out_item;

  assign issue_ok   = ({1'b0, out_cnt} + (OUT_CW+1)'(s1_v_q) + (OUT_CW+1)'(s2_v_q))
                      < (OUT_CW+1)'(OUT_QUEUE_DEPTH);
  assign q_ready_o  = !busy_q && (!q_data_i.is_sample || issue_ok);
  assign pop        = q_valid_i && q_ready_o;
  assign pop_sample = pop && q_data_i.is_sample;
  assign pop_load   = pop && !q_data_i.is_sample;

  assign inner_nxt  = {1'b0, inner_q} + 1'b1;
  assign ch_nxt     = {1'b0, ch_q} + 1'b1;
  assign inner_wrap = (CMP_W'(inner_nxt) >= CMP_W'(cfg_i.inner_size)) || inner_nxt[IN_W];
  assign ch_wrap    = (32'(ch_nxt) >= 32'(cfg_i.channel_count))
                      || (32'(ch_nxt) >= 32'(MAX_CHANNELS));

  always_comb begin
    busy_d  = busy_q;
    ch_d    = ch_q;
    inner_d = inner_q;
    if (pop_load) begin
      busy_d = 1'b1;
    end else if (gain_rsp.done) begin
      busy_d = 1'b0;
    end
    if (pop_sample) begin
      if (inner_wrap) begin
        inner_d = '0;
        ch_d    = ch_wrap ? '0 : ch_nxt[CH_W-1:0];
      end else begin
        inner_d = inner_nxt[IN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      ch_q    <= '0;
      inner_q <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      ch_q    <= ch_d;
      inner_q <= inner_d;
      s1_v_q  <= pop_sample;
      s2_v_q  <= s1_v_q;
    end
  end

  always_comb begin
    gain_req.start   = pop_load;
    gain_req.scale   = q_data_i.scale_value;
    gain_req.var_sum = VSUM_W'(q_data_i.variance_value) + VSUM_W'(cfg_i.epsilon);
  end

  bni_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gain_req),
    .rsp_o  (gain_rsp)
  );

  always_comb begin
    coef_wr.mean = ld_mean_q;
    coef_wr.gain = gain_rsp.gain;
    coef_wr.bias = ld_bias_q;
  end

  bni_ram #(
    .WIDTH ($bits(coef_t)),
    .DEPTH (MAX_CHANNELS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (gain_rsp.done),
    .waddr_i (ld_ch_q),
    .wdata_i (coef_wr),
    .raddr_i (ch_q),
    .rdata_o (coef_rd)
  );

  assign diff    = (DATA_W+1)'(s1_sample_q) - (DATA_W+1)'(coef_rd.mean);
  assign prod    = PROD_W'(diff) * PROD_W'(coef_rd.gain);
  assign bias_sh = {{(T_W-DATA_W-16){s2_bias_q[DATA_W-1]}}, s2_bias_q, 16'b0};
  assign t_sum   = T_W'(s2_prod_q) + bias_sh + T_W'(32768);
  assign y       = t_sum[T_W-1:16];
  assign sat     = !((&y[T_W-17:DATA_W-1]) || !(|y[T_W-17:DATA_W-1]));

  always_ff @(posedge clk_i) begin
    if (pop_load) begin
      ld_ch_q   <= CH_W'(q_data_i.channel);
      ld_mean_q <= q_data_i.mean_value;
      ld_bias_q <= q_data_i.bias_value;
    end
    s1_sample_q <= q_data_i.sample;
    s1_ch_q     <= ch_q;
    s2_ch_q     <= s1_ch_q;
    s2_prod_q   <= prod;
    s2_bias_q   <= coef_rd.bias;
  end

  always_comb begin
    item.saturated     = sat;
    item.channel_index = LD_CH_W'(s2_ch_q);
    if (sat) begin
      item.result_value = y[T_W-17] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      item.result_value = y[DATA_W-1:0];
    end
  end

  bni_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s2_v_q),
    .push_ready_o (),
    .push_data_i  (item),
    .pop_valid_o  (out_o.valid),
    .pop_ready_i  (out_o.ready),
    .pop_data_o   (out_item),
    .count_o      (out_cnt)
  );

  assign out_o.result_value  = out_item.result_value;
  assign out_o.saturated     = out_item.saturated;
  assign out_o.channel_index = out_item.channel_index;

endmodule
